// ----- src/tbrw_pkg.sv -----
// tbrw_pkg: shared widths, register indexes, result codes and cell control
// for the time-bin reorder window. No dependencies.
`default_nettype none
package tbrw_pkg;

	localparam int TIME_BIN_W  = 48;
	localparam int FREQ_ID_W   = 16;
	localparam int ACTION_W    = 2;
	localparam int OUT_SLOT_W  = 3;
	localparam int OUT_ROW_W   = 10;
	localparam int COUNT_W     = 32;

	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int ROWS_W      = 11;
	localparam int WIN_W       = 3;

	localparam int DEF_MAX_OPEN_BINS = 4;
	localparam int DEF_RING_FRAMES   = 8;
	localparam int DEF_MAX_FREQ_ROWS = 1024;

	localparam logic [CFG_IDX_W-1:0] REG_FREQ_BASE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_FREQ_ROWS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_OPEN_BINS = 2'd2;

	localparam logic [FREQ_ID_W-1:0] RST_FREQ_BASE     = 16'd0;
	localparam logic [ROWS_W-1:0]    RST_NUM_FREQ_ROWS = 11'd256;
	localparam logic [WIN_W-1:0]     RST_NUM_OPEN_BINS = 3'd2;

	localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_LATE  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_RANGE = 2'd2;

	// per-cell control from the window controller
	typedef struct packed {
		logic active;   // cell holds an open bin
		logic shift;    // take the right neighbor's entry
		logic load;     // take the new bin
	} cell_ctrl_t;

endpackage
`default_nettype wire

// ----- src/tbrw_if.sv -----
// tbrw_if: valid/ready channels for frame headers and placement results.
// Depends on tbrw_pkg for field widths.
`default_nettype none
interface tbrw_hdr_if;
	logic                             valid;
	logic                             ready;
	logic [tbrw_pkg::TIME_BIN_W-1:0]  time_bin;
	logic [tbrw_pkg::FREQ_ID_W-1:0]   freq_id;

	modport source (output valid, time_bin, freq_id, input ready);
	modport sink   (input valid, time_bin, freq_id, output ready);
endinterface

interface tbrw_res_if;
	logic                             valid;
	logic                             ready;
	logic [tbrw_pkg::ACTION_W-1:0]    action;
	logic [tbrw_pkg::OUT_SLOT_W-1:0]  frame_slot;
	logic [tbrw_pkg::OUT_ROW_W-1:0]   row;
	logic                             opened;
	logic                             flushed;
	logic [tbrw_pkg::OUT_SLOT_W-1:0]  flushed_slot;
	logic [tbrw_pkg::COUNT_W-1:0]     late_drops;
	logic [tbrw_pkg::COUNT_W-1:0]     range_drops;

	modport source (output valid, action, frame_slot, row, opened, flushed, flushed_slot,
		late_drops, range_drops, input ready);
	modport sink   (input valid, action, frame_slot, row, opened, flushed, flushed_slot,
		late_drops, range_drops, output ready);
endinterface
`default_nettype wire

// ----- src/tbrw_cell.sv -----
// tbrw_cell: one entry of the open-bin list; holds a bin and its frame slot,
// shifts toward the oldest end on a close. Depends on tbrw_pkg.
`default_nettype none
module tbrw_cell #(
	parameter int SLOT_W = 3
) (
	input  wire logic                             clk,
	input  wire tbrw_pkg::cell_ctrl_t             ctrl,
	input  wire logic [tbrw_pkg::TIME_BIN_W-1:0]  new_bin,
	input  wire logic [SLOT_W-1:0]                new_slot,
	input  wire logic [tbrw_pkg::TIME_BIN_W-1:0]  nbr_bin,
	input  wire logic [SLOT_W-1:0]                nbr_slot,
	input  wire logic [tbrw_pkg::TIME_BIN_W-1:0]  probe_bin,
	output logic [tbrw_pkg::TIME_BIN_W-1:0]       bin,
	output logic [SLOT_W-1:0]                     slot,
	output logic                                  hit
);

	logic [tbrw_pkg::TIME_BIN_W-1:0] bin_q;
	logic [SLOT_W-1:0]               slot_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			bin_q  <= new_bin;
			slot_q <= new_slot;
		end else if (ctrl.shift) begin
			bin_q  <= nbr_bin;
			slot_q <= nbr_slot;
		end
	end

	assign bin  = bin_q;
	assign slot = slot_q;
	assign hit  = ctrl.active && (bin_q == probe_bin);

endmodule
`default_nettype wire

// ----- src/time_bin_reorder_window.sv -----
// time_bin_reorder_window: top level; chain of open-bin cells, window control,
// drop counters and result register. Depends on tbrw_pkg, tbrw_if, tbrw_cell.
//
//   channel  dir  handshake     payload
//   hdr      in   valid/ready   time_bin, freq_id
//   res      out  valid/ready   action, frame_slot, row, opened, flushed,
//                               flushed_slot, late_drops, range_drops
//   cfg      in   cfg_we        cfg_idx, cfg_data (no back-pressure)
//
// One header per cycle while the result register is not stalled: the cell
// compares, the late check against the newest open bin and the row subtraction
// settle in the accept cycle; the result register presents the request in the next cycle.
// A header is taken while the result register is empty or being drained.
// arst_n clears list length, ring pointer, counters, result valid; resets config.
`default_nettype none
module time_bin_reorder_window #(
	parameter int MAX_OPEN_BINS = tbrw_pkg::DEF_MAX_OPEN_BINS,
	parameter int RING_FRAMES   = tbrw_pkg::DEF_RING_FRAMES,
	parameter int MAX_FREQ_ROWS = tbrw_pkg::DEF_MAX_FREQ_ROWS
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	tbrw_hdr_if.sink                              hdr,
	tbrw_res_if.source                            res,
	input  wire logic                             cfg_we,
	input  wire logic [tbrw_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  wire logic [tbrw_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int SLOT_W = (RING_FRAMES > 1) ? $clog2(RING_FRAMES) : 1;
	localparam int CNT_W  = $clog2(MAX_OPEN_BINS + 1);
	localparam int CMP_W  = (CNT_W > tbrw_pkg::WIN_W) ? CNT_W : tbrw_pkg::WIN_W;
	localparam int ROW_W  = tbrw_pkg::FREQ_ID_W + 1;
	localparam int BIN_W  = tbrw_pkg::TIME_BIN_W;
	localparam logic [CMP_W-1:0]  MAX_BINS_C = CMP_W'(MAX_OPEN_BINS);
	localparam logic [ROW_W-1:0]  MAX_ROWS_C = ROW_W'(MAX_FREQ_ROWS);
	localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(RING_FRAMES - 1);

	// config
	logic [tbrw_pkg::FREQ_ID_W-1:0] freq_base_q;
	logic [tbrw_pkg::ROWS_W-1:0]    num_freq_rows_q;
	logic [tbrw_pkg::WIN_W-1:0]     num_open_bins_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_base_q     <= tbrw_pkg::RST_FREQ_BASE;
			num_freq_rows_q <= tbrw_pkg::RST_NUM_FREQ_ROWS;
			num_open_bins_q <= tbrw_pkg::RST_NUM_OPEN_BINS;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				tbrw_pkg::REG_FREQ_BASE:     freq_base_q     <= cfg_data;
				tbrw_pkg::REG_NUM_FREQ_ROWS: num_freq_rows_q <= cfg_data[tbrw_pkg::ROWS_W-1:0];
				tbrw_pkg::REG_NUM_OPEN_BINS: num_open_bins_q <= cfg_data[tbrw_pkg::WIN_W-1:0];
				default: ;
			endcase
		end
	end

	// window state
	logic [CNT_W-1:0]  count_q;
	logic [SLOT_W-1:0] next_slot_q;
	logic [BIN_W-1:0]  newest_q;
	logic [tbrw_pkg::COUNT_W-1:0] late_cnt_q, range_cnt_q;

	logic accept;
	logic res_valid_q;
	assign hdr.ready = !res_valid_q || res.ready;
	assign accept    = hdr.valid && hdr.ready;

	// cell chain; entry MAX_OPEN_BINS is the empty neighbor past the end
	logic [BIN_W-1:0]          cell_bin  [MAX_OPEN_BINS+1];
	logic [SLOT_W-1:0]         cell_slot [MAX_OPEN_BINS+1];
	logic [MAX_OPEN_BINS-1:0]  cell_hit;
	tbrw_pkg::cell_ctrl_t      cell_ctrl [MAX_OPEN_BINS];
	logic [SLOT_W-1:0]         hit_slot_part [MAX_OPEN_BINS+1];

	logic             found, late, open_new, flush;
	logic [CMP_W-1:0] count_ext, limit;
	logic [CNT_W-1:0] wr_pos;

	assign cell_bin[MAX_OPEN_BINS]      = '0;
	assign cell_slot[MAX_OPEN_BINS]     = '0;
	assign hit_slot_part[MAX_OPEN_BINS] = '0;

	for (genvar i = 0; i < MAX_OPEN_BINS; i++) begin : g_cell
		always_comb begin
			cell_ctrl[i].active = (CNT_W'(i) < count_q);
			cell_ctrl[i].shift  = open_new && flush;
			cell_ctrl[i].load   = open_new && (wr_pos == CNT_W'(i));
		end

		tbrw_cell #(.SLOT_W(SLOT_W)) u_cell (
			.clk       (clk),
			.ctrl      (cell_ctrl[i]),
			.new_bin   (hdr.time_bin),
			.new_slot  (next_slot_q),
			.nbr_bin   (cell_bin[i+1]),
			.nbr_slot  (cell_slot[i+1]),
			.probe_bin (hdr.time_bin),
			.bin       (cell_bin[i]),
			.slot      (cell_slot[i]),
			.hit       (cell_hit[i])
		);

		// open bins are distinct, so at most one cell hits
		assign hit_slot_part[i] = hit_slot_part[i+1] | (cell_hit[i] ? cell_slot[i] : '0);
	end

	always_comb begin
		count_ext = CMP_W'(count_q);
		if (num_open_bins_q == '0)
			limit = CMP_W'(1);
		else if (CMP_W'(num_open_bins_q) > MAX_BINS_C)
			limit = MAX_BINS_C;
		else
			limit = CMP_W'(num_open_bins_q);
		found    = |cell_hit;
		late     = !found && (count_q != '0) && (hdr.time_bin < newest_q);
		open_new = accept && !found && !late;
		flush    = (count_ext >= limit) && (count_q != '0);
		wr_pos   = flush ? count_q - CNT_W'(1) : count_q;
	end

	// row mapping
	logic [ROW_W-1:0] diff, rows_eff;
	logic             in_range;
	always_comb begin
		diff     = ROW_W'(hdr.freq_id) - ROW_W'(freq_base_q);
		rows_eff = (ROW_W'(num_freq_rows_q) > MAX_ROWS_C) ? MAX_ROWS_C
			: ROW_W'(num_freq_rows_q);
		in_range = !diff[ROW_W-1] && (diff < rows_eff);
	end

	// result fields for this header
	logic [tbrw_pkg::ACTION_W-1:0] action_d;
	logic [SLOT_W-1:0]             slot_d;
	logic [tbrw_pkg::COUNT_W-1:0]  late_cnt_d, range_cnt_d;
	logic [SLOT_W+2:0]             slot_ext, fslot_ext;
	always_comb begin
		late_cnt_d  = late_cnt_q;
		range_cnt_d = range_cnt_q;
		slot_d      = found ? hit_slot_part[0] : next_slot_q;
		if (late) begin
			action_d = tbrw_pkg::ACT_LATE;
			slot_d   = '0;
			if (late_cnt_q != '1)
				late_cnt_d = late_cnt_q + 1'b1;
		end else if (!in_range) begin
			action_d = tbrw_pkg::ACT_RANGE;
			if (range_cnt_q != '1)
				range_cnt_d = range_cnt_q + 1'b1;
		end else begin
			action_d = tbrw_pkg::ACT_WRITE;
		end
		slot_ext  = {3'b000, slot_d};
		fslot_ext = {3'b000, cell_slot[0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			next_slot_q <= '0;
			late_cnt_q  <= '0;
			range_cnt_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				late_cnt_q  <= late_cnt_d;
				range_cnt_q <= range_cnt_d;
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			if (open_new) begin
				count_q     <= wr_pos + CNT_W'(1);
				next_slot_q <= (next_slot_q == LAST_SLOT) ? '0 : next_slot_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (open_new)
			newest_q <= hdr.time_bin;
	end

	// result register
	logic [tbrw_pkg::ACTION_W-1:0]   action_q;
	logic [tbrw_pkg::OUT_SLOT_W-1:0] slot_q, fslot_q;
	logic [tbrw_pkg::OUT_ROW_W-1:0]  row_q;
	logic                            opened_q, flushed_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			action_q  <= action_d;
			slot_q    <= slot_ext[tbrw_pkg::OUT_SLOT_W-1:0];
			row_q     <= (action_d == tbrw_pkg::ACT_WRITE) ? diff[tbrw_pkg::OUT_ROW_W-1:0] : '0;
			opened_q  <= open_new;
			flushed_q <= open_new && flush;
			fslot_q   <= (open_new && flush) ? fslot_ext[tbrw_pkg::OUT_SLOT_W-1:0] : '0;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.action       = action_q;
	assign res.frame_slot   = slot_q;
	assign res.row          = row_q;
	assign res.opened       = opened_q;
	assign res.flushed      = flushed_q;
	assign res.flushed_slot = fslot_q;
	assign res.late_drops   = late_cnt_q;
	assign res.range_drops  = range_cnt_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(count_q) <= MAX_BINS_C)
		else $error("open list longer than the cell chain");

	a_flush_opens: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.flushed |-> res.opened)
		else $error("bin closed without a new bin opened");

	a_late_holds_list: assert property (@(posedge clk) disable iff (!arst_n)
		accept && late |=> $stable(count_q) && $stable(next_slot_q))
		else $error("late request changed the window");

	a_late_slot: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.action == tbrw_pkg::ACT_LATE |-> !res.opened && res.frame_slot == '0)
		else $error("late request carries a slot");

endmodule
`default_nettype wire
